@@ hw/rtl/icpt_pkg.sv @@
// shared types and constants for the inline cache probe table
// opcodes, field widths and the command/status bundle between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package icpt_pkg;

   localparam int DATA_W    = 32;
   localparam int HASH_W    = 32;
   localparam int ARITY_W   = 3;
   localparam int OP_W      = 2;
   localparam int REQ_MAPS  = 4;
   localparam int USED_W    = 4;

   // hash reduction: four hash bits folded into the remainder per cycle
   localparam int MOD_DIGIT_W = 4;
   localparam int MOD_STEPS   = HASH_W / MOD_DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(MOD_STEPS);

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic probe_step;
   } icpt_cmd_type;

   typedef struct packed {
      logic mod_last;
      logic probe_end;
   } icpt_sts_type;

endpackage

@@ hw/rtl/icpt_ctrl.sv @@
// controller state machine for the inline cache probe table
// sequences load, hash reduction, slot probe and result; uses icpt_pkg
`timescale 1ns / 1ps

module icpt_ctrl
   import icpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [OP_W-1:0]    req_opcode,
   input  icpt_sts_type       sts,
   output icpt_cmd_type       cmd,
   output logic               busy,
   output logic               rsp_strobe
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MOD   = 4'b0010,
      ST_PROBE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.load       = 1'b0;
      cmd.mod_step   = 1'b0;
      cmd.probe_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               // clear and the unused code skip the reduction and probe and go straight to done
               if (req_opcode == OP_LOOKUP || req_opcode == OP_INSERT) begin
                  state_in = ST_MOD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            cmd.probe_step = 1'b1;
            if (sts.probe_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);

endmodule

@@ hw/rtl/icpt_dp.sv @@
// datapath of the inline cache probe table: request capture, hash remainder,
// slot memories, valid bits, match logic and result registers; uses icpt_pkg
`timescale 1ns / 1ps

module icpt_dp
   import icpt_pkg::*;
#(
   parameter int ENTRIES  = 16,
   parameter int MAX_ARGS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  icpt_cmd_type         cmd,
   output icpt_sts_type         sts,
   input  logic [OP_W-1:0]      req_opcode,
   input  logic [HASH_W-1:0]    req_call_hash,
   input  logic [DATA_W-1:0]    req_selector_id,
   input  logic [ARITY_W-1:0]   req_arg_count,
   input  logic [DATA_W-1:0]    req_target_id,
   input  logic [DATA_W-1:0]    req_map_zero,
   input  logic [DATA_W-1:0]    req_map_one,
   input  logic [DATA_W-1:0]    req_map_two,
   input  logic [DATA_W-1:0]    req_map_three,
   output logic                 rsp_hit,
   output logic [DATA_W-1:0]    rsp_found_target,
   output logic [DATA_W-1:0]    rsp_use_count,
   output logic                 rsp_inserted,
   output logic                 rsp_table_full
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W:0]   ENTRIES_V = (IDX_W + 1)'(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] STEPS_ALL = CNT_W'(ENTRIES);

   typedef logic [MAX_ARGS-1:0][DATA_W-1:0] maps_type;

   // slot memories
   logic [DATA_W-1:0]  slot_target_ff   [ENTRIES];
   logic [DATA_W-1:0]  slot_selector_ff [ENTRIES];
   logic [ARITY_W-1:0] slot_arity_ff    [ENTRIES];
   maps_type           slot_maps_ff     [ENTRIES];
   logic [DATA_W-1:0]  slot_count_ff    [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;

   // registered read data
   logic [DATA_W-1:0]  rd_target_ff, rd_selector_ff, rd_count_ff;
   logic [ARITY_W-1:0] rd_arity_ff;
   maps_type           rd_maps_ff;

   // captured request
   logic [OP_W-1:0]    op_ff, op_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [DATA_W-1:0]  sel_ff, sel_in;
   logic [ARITY_W-1:0] arity_ff, arity_in;
   logic [DATA_W-1:0]  tgt_ff, tgt_in;
   maps_type           maps_ff, maps_in;

   // probe control
   logic [IDX_W-1:0]       rem_ff, rem_in;
   logic [DIGIT_CNT_W-1:0] digit_ff, digit_in;
   logic [IDX_W-1:0]       probe_idx_ff, probe_idx_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [CNT_W-1:0]       steps_ff, steps_in;

   // results
   logic               hit_ff, hit_in;
   logic [DATA_W-1:0]  found_ff, found_in;
   logic [DATA_W-1:0]  count_ff, count_in;
   logic               inserted_ff, inserted_in;
   logic               full_ff, full_in;

   logic [DATA_W-1:0]  req_map_arr [REQ_MAPS];
   logic [IDX_W-1:0]   rem_next;
   logic [USED_W-1:0]  used_cnt;
   logic               is_insert, maps_ok, match, found, exhausted, empty;
   logic [DATA_W-1:0]  count_inc;
   logic               wr_entry;
   logic               wr_count;
   logic [IDX_W-1:0]   wr_count_addr;
   logic [DATA_W-1:0]  wr_count_data;

   assign req_map_arr[0] = req_map_zero;
   assign req_map_arr[1] = req_map_one;
   assign req_map_arr[2] = req_map_two;
   assign req_map_arr[3] = req_map_three;

   // remainder of the hash by ENTRIES, msb first, one compare-subtract per bit
   always_comb begin
      logic [IDX_W-1:0] rem_v;
      logic [IDX_W:0]   trial;
      rem_v = rem_ff;
      for (int b = 0; b < MOD_DIGIT_W; b++) begin
         trial = {rem_v, hash_ff[HASH_W-1-b]};
         if (trial >= ENTRIES_V) begin
            trial = trial - ENTRIES_V;
         end
         rem_v = trial[IDX_W-1:0];
      end
      rem_next = rem_v;
   end

   assign is_insert = (op_ff == OP_INSERT);
   assign used_cnt  = ({1'b0, arity_ff} > USED_W'(MAX_ARGS)) ? USED_W'(MAX_ARGS)
                                                            : {1'b0, arity_ff};

   always_comb begin
      maps_ok = 1'b1;
      for (int k = 0; k < MAX_ARGS; k++) begin
         if (USED_W'(k) < used_cnt && rd_maps_ff[k] != maps_ff[k]) begin
            maps_ok = 1'b0;
         end
      end
   end

   assign match     = maps_ok && (rd_selector_ff == sel_ff) && (rd_arity_ff == arity_ff);
   assign found     = cmp_valid_ff && match;
   assign exhausted = (steps_ff == STEPS_ALL);
   assign empty     = !valid_ff[probe_idx_ff] && !exhausted;
   assign count_inc = (rd_count_ff == '1) ? rd_count_ff : rd_count_ff + DATA_W'(1);

   assign sts.mod_last  = (digit_ff == DIGIT_CNT_W'(MOD_STEPS - 1));
   assign sts.probe_end = found || empty || exhausted;

   always_comb begin
      op_in        = op_ff;
      hash_in      = hash_ff;
      sel_in       = sel_ff;
      arity_in     = arity_ff;
      tgt_in       = tgt_ff;
      maps_in      = maps_ff;
      rem_in       = rem_ff;
      digit_in     = digit_ff;
      probe_idx_in = probe_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      steps_in     = steps_ff;
      valid_in     = valid_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      inserted_in  = inserted_ff;
      full_in      = full_ff;
      wr_entry      = 1'b0;
      wr_count      = 1'b0;
      wr_count_addr = probe_idx_ff;
      wr_count_data = DATA_W'(1);

      if (cmd.load) begin
         op_in    = req_opcode;
         hash_in  = req_call_hash;
         sel_in   = req_selector_id;
         arity_in = req_arg_count;
         tgt_in   = req_target_id;
         for (int k = 0; k < MAX_ARGS; k++) begin
            maps_in[k] = (k < REQ_MAPS) ? req_map_arr[2'(k)] : '0;
         end
         rem_in      = '0;
         digit_in    = '0;
         hit_in      = 1'b0;
         found_in    = '0;
         count_in    = '0;
         inserted_in = 1'b0;
         full_in     = 1'b0;
         if (req_opcode == OP_CLEAR) begin
            valid_in = '0;
         end
      end

      if (cmd.mod_step) begin
         hash_in      = hash_ff << MOD_DIGIT_W;
         rem_in       = rem_next;
         digit_in     = digit_ff + DIGIT_CNT_W'(1);
         probe_idx_in = rem_next;
         cmp_valid_in = 1'b0;
         steps_in     = '0;
      end

      if (cmd.probe_step) begin
         priority if (found) begin
            // slot issued last cycle matches
            hit_in        = 1'b1;
            found_in      = rd_target_ff;
            count_in      = count_inc;
            wr_count      = 1'b1;
            wr_count_addr = cmp_idx_ff;
            wr_count_data = count_inc;
         end else if (empty) begin
            if (is_insert) begin
               wr_entry                = 1'b1;
               wr_count                = 1'b1;
               valid_in[probe_idx_ff]  = 1'b1;
               inserted_in             = 1'b1;
            end
         end else if (exhausted) begin
            full_in = is_insert;
         end else begin
            cmp_valid_in = !is_insert;
            cmp_idx_in   = probe_idx_ff;
            probe_idx_in = (probe_idx_ff == LAST_IDX) ? '0 : probe_idx_ff + IDX_W'(1);
            steps_in     = steps_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      hash_ff      <= hash_in;
      sel_ff       <= sel_in;
      arity_ff     <= arity_in;
      tgt_ff       <= tgt_in;
      maps_ff      <= maps_in;
      rem_ff       <= rem_in;
      digit_ff     <= digit_in;
      probe_idx_ff <= probe_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      cmp_valid_ff <= cmp_valid_in;
      steps_ff     <= steps_in;
      hit_ff       <= hit_in;
      found_ff     <= found_in;
      count_ff     <= count_in;
      inserted_ff  <= inserted_in;
      full_ff      <= full_in;
   end

   // entry memories: written on insert, read every cycle at the probe slot
   always_ff @(posedge clock) begin
      if (wr_entry) begin
         slot_target_ff[probe_idx_ff]   <= tgt_ff;
         slot_selector_ff[probe_idx_ff] <= sel_ff;
         slot_arity_ff[probe_idx_ff]    <= arity_ff;
         slot_maps_ff[probe_idx_ff]     <= maps_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_target_ff   <= slot_target_ff[probe_idx_ff];
      rd_selector_ff <= slot_selector_ff[probe_idx_ff];
      rd_arity_ff    <= slot_arity_ff[probe_idx_ff];
      rd_maps_ff     <= slot_maps_ff[probe_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (wr_count) begin
         slot_count_ff[wr_count_addr] <= wr_count_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_count_ff <= slot_count_ff[probe_idx_ff];
   end

   assign rsp_hit          = hit_ff;
   assign rsp_found_target = found_ff;
   assign rsp_use_count    = count_ff;
   assign rsp_inserted     = inserted_ff;
   assign rsp_table_full   = full_ff;

endmodule

@@ hw/rtl/inline_cache_probe_table.sv @@
// top level of the inline cache probe table: controller plus datapath
// depends on icpt_pkg, icpt_ctrl and icpt_dp
`timescale 1ns / 1ps

// Polymorphic inline cache with open addressing over ENTRIES slots. A command
// is taken when start is high and busy is low; exactly one result follows,
// shown for a single cycle with rsp_strobe high, and it cannot be held off.
// Lookup and insert first reduce call_hash modulo ENTRIES, four hash bits per
// cycle, then probe one slot per cycle through the slot memories, whose read
// is registered. Clear and the unused opcode answer in the next cycle; busy
// drops in the cycle after the result, so a new command is taken only once
// the last result is out. There is no clearing pass after reset: valid bits
// clear at once.
module inline_cache_probe_table
   import icpt_pkg::*;
#(
   parameter int ENTRIES  = 16,
   parameter int MAX_ARGS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_opcode,
   input  logic [HASH_W-1:0]    req_call_hash,
   input  logic [DATA_W-1:0]    req_selector_id,
   input  logic [ARITY_W-1:0]   req_arg_count,
   input  logic [DATA_W-1:0]    req_target_id,
   input  logic [DATA_W-1:0]    req_map_zero,
   input  logic [DATA_W-1:0]    req_map_one,
   input  logic [DATA_W-1:0]    req_map_two,
   input  logic [DATA_W-1:0]    req_map_three,
   output logic                 rsp_strobe,
   output logic                 rsp_hit,
   output logic [DATA_W-1:0]    rsp_found_target,
   output logic [DATA_W-1:0]    rsp_use_count,
   output logic                 rsp_inserted,
   output logic                 rsp_table_full
);

   icpt_cmd_type cmd;
   icpt_sts_type sts;

   icpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   icpt_dp #(
      .ENTRIES  (ENTRIES),
      .MAX_ARGS (MAX_ARGS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_call_hash    (req_call_hash),
      .req_selector_id  (req_selector_id),
      .req_arg_count    (req_arg_count),
      .req_target_id    (req_target_id),
      .req_map_zero     (req_map_zero),
      .req_map_one      (req_map_one),
      .req_map_two      (req_map_two),
      .req_map_three    (req_map_three),
      .rsp_hit          (rsp_hit),
      .rsp_found_target (rsp_found_target),
      .rsp_use_count    (rsp_use_count),
      .rsp_inserted     (rsp_inserted),
      .rsp_table_full   (rsp_table_full)
   );

   // a transfer in makes the block busy until its result has gone out
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a command transfer");

   // the block is free again right after a result
   a_strobe_release: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!busy && !rsp_strobe))
      else $error("block still busy after result");

   // a hit never comes with insert status
   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_hit && (rsp_inserted || rsp_table_full)))
      else $error("hit and insert status together");

   // a miss or a non-lookup carries zero target and count
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |-> (rsp_found_target == '0 && rsp_use_count == '0))
      else $error("nonzero target or count without a hit");

   // a hit never reports a zero count
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit) |-> (rsp_use_count != '0))
      else $error("hit with zero use count");

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for inline_cache_probe_table: directed table then random traffic
// predicts every probe result with a slot-level model of the table; depends on icpt_pkg
`timescale 1ns / 1ps

module tb_top;
   import icpt_pkg::*;

   localparam int TABLE_SLOTS = 16;
   localparam int ARG_MAPS    = 4;
   localparam int RANDOM_ITEMS = 800;
   localparam int MAX_RESULT_WAIT = TABLE_SLOTS + 12;
   localparam int CYCLE_LIMIT = 300000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]              opcode;
      logic [HASH_W-1:0]            call_hash;
      logic [DATA_W-1:0]            selector;
      logic [ARITY_W-1:0]           arity;
      logic [DATA_W-1:0]            target;
      logic [ARG_MAPS-1:0][DATA_W-1:0] maps;
   } cache_cmd_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] found_target;
      logic [DATA_W-1:0] use_count;
      logic              inserted;
      logic              table_full;
   } probe_result_type;

   typedef struct {
      cache_cmd_type    cmd;
      int               reps;
      bit               typed;
      probe_result_type want;
   } table_row_type;

   localparam probe_result_type ALL_ZERO  = '0;
   localparam probe_result_type NEW_ENTRY = '{1'b0, 32'd0, 32'd0, 1'b1, 1'b0};
   localparam probe_result_type FULL_FLAG = '{1'b0, 32'd0, 32'd0, 1'b0, 1'b1};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [OP_W-1:0]    req_opcode = '0;
   logic [HASH_W-1:0]  req_call_hash = '0;
   logic [DATA_W-1:0]  req_selector_id = '0;
   logic [ARITY_W-1:0] req_arg_count = '0;
   logic [DATA_W-1:0]  req_target_id = '0;
   logic [DATA_W-1:0]  req_map_zero = '0;
   logic [DATA_W-1:0]  req_map_one = '0;
   logic [DATA_W-1:0]  req_map_two = '0;
   logic [DATA_W-1:0]  req_map_three = '0;
   logic               rsp_strobe;
   logic               rsp_hit;
   logic [DATA_W-1:0]  rsp_found_target;
   logic [DATA_W-1:0]  rsp_use_count;
   logic               rsp_inserted;
   logic               rsp_table_full;

   // mirror of the slot memories
   logic                            slot_live  [TABLE_SLOTS];
   logic [DATA_W-1:0]               slot_tgt   [TABLE_SLOTS];
   logic [DATA_W-1:0]               slot_sel   [TABLE_SLOTS];
   logic [ARITY_W-1:0]              slot_ar    [TABLE_SLOTS];
   logic [DATA_W-1:0]               slot_cnt   [TABLE_SLOTS];
   logic [ARG_MAPS-1:0][DATA_W-1:0] slot_map   [TABLE_SLOTS];

   probe_result_type pending_results[$];
   cache_cmd_type    cached_keys[$];
   table_row_type    stimulus_table[$];
   int               mismatch_count = 0;
   int               steady_left = 0;
   int               cycle_count = 0;

   inline_cache_probe_table #(
      .ENTRIES (TABLE_SLOTS),
      .MAX_ARGS(ARG_MAPS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_call_hash   (req_call_hash),
      .req_selector_id (req_selector_id),
      .req_arg_count   (req_arg_count),
      .req_target_id   (req_target_id),
      .req_map_zero    (req_map_zero),
      .req_map_one     (req_map_one),
      .req_map_two     (req_map_two),
      .req_map_three   (req_map_three),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_found_target(rsp_found_target),
      .rsp_use_count   (rsp_use_count),
      .rsp_inserted    (rsp_inserted),
      .rsp_table_full  (rsp_table_full)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic cache_cmd_type make_cmd(input logic [OP_W-1:0] op,
                                              input logic [HASH_W-1:0] hash,
                                              input logic [DATA_W-1:0] sel,
                                              input logic [ARITY_W-1:0] arity,
                                              input logic [DATA_W-1:0] tgt,
                                              input logic [DATA_W-1:0] m0,
                                              input logic [DATA_W-1:0] m1,
                                              input logic [DATA_W-1:0] m2,
                                              input logic [DATA_W-1:0] m3);
      cache_cmd_type c;
      c.opcode = op;
      c.call_hash = hash;
      c.selector = sel;
      c.arity = arity;
      c.target = tgt;
      c.maps[0] = m0;
      c.maps[1] = m1;
      c.maps[2] = m2;
      c.maps[3] = m3;
      return c;
   endfunction

   function automatic int maps_compared(input logic [ARITY_W-1:0] arity);
      return (arity > ARG_MAPS) ? ARG_MAPS : int'(arity);
   endfunction

   function automatic bit entry_matches(input int s, input cache_cmd_type c);
      bit same;
      same = (slot_sel[s] == c.selector) && (slot_ar[s] == c.arity);
      for (int k = 0; k < maps_compared(c.arity); k++)
         if (slot_map[s][k] != c.maps[k]) same = 1'b0;
      return same;
   endfunction

   // walks the probe path and updates the mirror as the block would
   function automatic probe_result_type predict_probe(input cache_cmd_type c);
      probe_result_type r;
      int               first;
      int               s;
      bit               done;
      r = '0;
      done = 1'b0;
      first = int'(c.call_hash % TABLE_SLOTS);
      if (c.opcode == OP_LOOKUP) begin
         for (int i = 0; i < TABLE_SLOTS && !done; i++) begin
            s = (first + i) % TABLE_SLOTS;
            if (!slot_live[s]) begin
               done = 1'b1;
            end else if (entry_matches(s, c)) begin
               if (slot_cnt[s] != 32'hFFFF_FFFF) slot_cnt[s] = slot_cnt[s] + 1;
               r.hit = 1'b1;
               r.found_target = slot_tgt[s];
               r.use_count = slot_cnt[s];
               done = 1'b1;
            end
         end
      end else if (c.opcode == OP_INSERT) begin
         r.table_full = 1'b1;
         for (int i = 0; i < TABLE_SLOTS && !done; i++) begin
            s = (first + i) % TABLE_SLOTS;
            if (!slot_live[s]) begin
               slot_live[s] = 1'b1;
               slot_tgt[s] = c.target;
               slot_sel[s] = c.selector;
               slot_ar[s] = c.arity;
               slot_cnt[s] = 32'd1;
               for (int k = 0; k < maps_compared(c.arity); k++) slot_map[s][k] = c.maps[k];
               r.inserted = 1'b1;
               r.table_full = 1'b0;
               done = 1'b1;
            end
         end
      end else if (c.opcode == OP_CLEAR) begin
         foreach (slot_live[i]) slot_live[i] = 1'b0;
      end
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_command(input cache_cmd_type c, input bit typed,
                               input probe_result_type want);
      probe_result_type predicted;
      start <= 1'b1;
      req_opcode <= c.opcode;
      req_call_hash <= c.call_hash;
      req_selector_id <= c.selector;
      req_arg_count <= c.arity;
      req_target_id <= c.target;
      req_map_zero <= c.maps[0];
      req_map_one <= c.maps[1];
      req_map_two <= c.maps[2];
      req_map_three <= c.maps[3];
      // busy is stable between edges, so its value here decides the next rising edge
      while (busy) @(negedge clock);
      predicted = predict_probe(c);
      pending_results.push_back(typed ? want : predicted);
      if (predicted.inserted) begin
         cached_keys.push_back(c);
         if (cached_keys.size() > 24) void'(cached_keys.pop_front());
      end
      if (c.opcode == OP_CLEAR) cached_keys.delete();
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int n;
      int roll;
      n = 0;
      if (steady_left > 0) begin
         steady_left--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 2) steady_left = 30;
         else if (roll < 55) n = 0;
         else if (roll < 90) n = $urandom_range(1, 3);
         else n = $urandom_range(10, 40);
      end
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic cache_cmd_type random_cmd();
      cache_cmd_type c;
      logic [DATA_W-1:0] sel;
      logic [ARITY_W-1:0] arity;
      int roll;
      int mi;
      int bi;
      roll = $urandom_range(0, 99);
      sel = ($urandom_range(0, 1) == 0) ? DATA_W'($urandom_range(0, 7)) : $urandom;
      arity = ($urandom_range(0, 9) < 8) ? ARITY_W'($urandom_range(0, 4))
                                         : ARITY_W'($urandom_range(5, 7));
      c = make_cmd(OP_LOOKUP, $urandom, sel, arity, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
      if (roll < 4) begin
         c.opcode = OP_CLEAR;
      end else if (roll < 6) begin
         c.opcode = OP_UNUSED;
      end else if (roll < 36) begin
         // re-inserting a known key exercises duplicate entries
         if (cached_keys.size() > 0 && $urandom_range(0, 9) < 4) begin
            c = cached_keys[$urandom_range(0, cached_keys.size() - 1)];
            c.target = $urandom;
         end
         c.opcode = OP_INSERT;
      end else if (cached_keys.size() > 0 && $urandom_range(0, 99) < 85) begin
         c = cached_keys[$urandom_range(0, cached_keys.size() - 1)];
         c.opcode = OP_LOOKUP;
         c.target = $urandom;
         for (int k = maps_compared(c.arity); k < ARG_MAPS; k++) c.maps[k] = $urandom;
         if ($urandom_range(0, 9) < 2) begin
            mi = $urandom_range(0, ARG_MAPS - 1);
            bi = $urandom_range(0, DATA_W - 1);
            case ($urandom_range(0, 3))
               0: c.maps[mi][bi] = ~c.maps[mi][bi];
               1: c.arity = c.arity + ARITY_W'($urandom_range(1, 7));
               2: c.selector[bi] = ~c.selector[bi];
               default: c.call_hash = c.call_hash + $urandom_range(1, 15);
            endcase
         end
      end
      return c;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result transfer: hit %0b target %h count %h ins %0b full %0b",
                        rsp_hit, rsp_found_target, rsp_use_count, rsp_inserted,
                        rsp_table_full);
         end else begin
            probe_result_type want;
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit || rsp_found_target !== want.found_target ||
                rsp_use_count !== want.use_count || rsp_inserted !== want.inserted ||
                rsp_table_full !== want.table_full) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: exp hit %0b target %h count %h ins %0b full %0b",
                           want.hit, want.found_target, want.use_count, want.inserted,
                           want.table_full);
                  $display("          got hit %0b target %h count %h ins %0b full %0b",
                           rsp_hit, rsp_found_target, rsp_use_count, rsp_inserted,
                           rsp_table_full);
               end
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      cache_cmd_type c;
      foreach (slot_live[i]) slot_live[i] = 1'b0;

      // key extremes, arity handling, duplicates, unused opcode, clear, full table
      stimulus_table.push_back('{make_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 3'd0, 32'h0,
                                          32'h0, 32'h0, 32'h0, 32'h0), 1, 1'b1, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 1'b1, NEW_ENTRY});
      stimulus_table.push_back('{make_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4,
                                          32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 1'b1,
                                 '{1'b1, 32'hFFFF_FFFF, 32'd2, 1'b0, 1'b0}});
      stimulus_table.push_back('{make_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4,
                                          32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'h0), 1, 1'b0, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_INSERT, 32'h0, 32'h0, 3'd0, 32'h0,
                                          32'h0, 32'h0, 32'h0, 32'h0), 1, 1'b1, NEW_ENTRY});
      // maps beyond the arity are not compared
      stimulus_table.push_back('{make_cmd(OP_LOOKUP, 32'h10, 32'h0, 3'd0, 32'h0,
                                          32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h1, 32'h2),
                                 1, 1'b0, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_INSERT, 32'h8000_000E, 32'h5, 3'd7,
                                          32'h1234_5678, 32'h1, 32'h2, 32'h3, 32'h4),
                                 1, 1'b0, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_LOOKUP, 32'h8000_000E, 32'h5, 3'd7, 32'h0,
                                          32'h1, 32'h2, 32'h3, 32'h4), 1, 1'b0, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_LOOKUP, 32'h8000_000E, 32'h5, 3'd4, 32'h0,
                                          32'h1, 32'h2, 32'h3, 32'h4), 1, 1'b0, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_INSERT, 32'h8000_000E, 32'h5, 3'd7,
                                          32'h8765_4321, 32'h1, 32'h2, 32'h3, 32'h4),
                                 1, 1'b0, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_LOOKUP, 32'h8000_000E, 32'h5, 3'd7, 32'h0,
                                          32'h1, 32'h2, 32'h3, 32'h4), 1, 1'b0, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_UNUSED, 32'hFFFF_FFFF, 32'h5, 3'd7,
                                          32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3, 32'h4),
                                 1, 1'b1, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_CLEAR, 32'h0, 32'h0, 3'd0, 32'h0,
                                          32'h0, 32'h0, 32'h0, 32'h0), 1, 1'b1, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4,
                                          32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 1'b1, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_INSERT, 32'h5, 32'h100, 3'd2, 32'hC000_0000,
                                          32'h11, 32'h22, 32'h33, 32'h44),
                                 TABLE_SLOTS, 1'b1, NEW_ENTRY});
      stimulus_table.push_back('{make_cmd(OP_INSERT, 32'h7, 32'h200, 3'd1, 32'h1,
                                          32'h11, 32'h0, 32'h0, 32'h0), 1, 1'b1, FULL_FLAG});
      // full table and no match: the walk covers all slots and misses
      stimulus_table.push_back('{make_cmd(OP_LOOKUP, 32'h3, 32'hDEAD_BEEF, 3'd2, 32'h0,
                                          32'h11, 32'h22, 32'h0, 32'h0), 1, 1'b1, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_LOOKUP, 32'h5, 32'h100, 3'd2, 32'h0,
                                          32'h11, 32'h22, 32'h33, 32'h44),
                                 TABLE_SLOTS, 1'b0, ALL_ZERO});
      stimulus_table.push_back('{make_cmd(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 1'b1, ALL_ZERO});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stimulus_table[r]) begin
         for (int i = 0; i < stimulus_table[r].reps; i++) begin
            c = stimulus_table[r].cmd;
            c.call_hash = c.call_hash + i;
            c.selector = c.selector + i;
            c.target = c.target + i;
            send_command(c, stimulus_table[r].typed, stimulus_table[r].want);
            idle_gap();
         end
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_command(random_cmd(), 1'b0, ALL_ZERO);
         idle_gap();
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (MAX_RESULT_WAIT) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
